### rtl/core/rfsd_pkg.sv
// Shared types and constants for the record format stream decoder.
// Holds the parse phases, result kinds, status codes and the result word layout.
// No dependencies.
package rfsd_pkg;

  // Parse phase of the record in progress
  typedef enum logic [2:0] {
    PH_HEAD    = 3'd0,
    PH_BITMAP  = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // End of record status
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_SHORT    = 3'd2,
    ST_NULLPAY  = 3'd3,
    ST_TRAILING = 3'd4,
    ST_TOOMANY  = 3'd5
  } status_t;

  // One result word
  typedef struct packed {
    kind_t       kind;
    logic [15:0] field_index;
    logic [7:0]  type_code;
    logic [15:0] field_length;
    logic        field_null;
    logic [7:0]  payload_byte;
    status_t     status;
    logic        last;
  } res_t;

  // Results raised by one accepted input word (up to two, in order)
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Output queue geometry
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;
  localparam int OUT_CW    = 3;

endpackage

### rtl/core/record_format_stream_decoder.sv
// Top level of the record format stream decoder.
// Depends on rfsd_pkg, rfsd_parser and rfsd_out_fifo.
//
// Takes one byte of an encoded row per input word: a word is taken every cycle
// while the four-entry result queue has room for two results. A word that raises
// two results (a header or payload byte together with the end status) fills the
// queue faster than it drains, at most one result a cycle, so such words can hold
// off the next input word. The null bitmap lives in a RAM with registered read data
// of MAX_BITMAP_BYTES bytes; it is read when a field's type byte is taken, so the
// null bit is ready for the length bytes. The store needs no clearing pass: only
// entries written for the current row are read. Results of a row whose end status
// is not ok should be discarded by the consumer.
module record_format_stream_decoder #(
  parameter int MAX_BITMAP_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  input  logic        in_no_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_field_index,
  output logic [7:0]  out_type_code,
  output logic [15:0] out_field_length,
  output logic        out_field_null,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_status,
  output logic        out_last
);

  logic            in_accept;
  rfsd_pkg::push_t push;
  rfsd_pkg::res_t  head;

  assign in_accept = in_valid && !in_stall;

  // Byte parser
  rfsd_parser #(
    .MAX_BITMAP_BYTES (MAX_BITMAP_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_data_byte (in_data_byte),
    .in_is_last   (in_is_last),
    .in_no_data   (in_no_data),
    .push         (push)
  );

  // Result queue
  rfsd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .in_stall  (in_stall)
  );

  // Result word onto the ports
  assign out_kind         = head.kind;
  assign out_field_index  = head.field_index;
  assign out_type_code    = head.type_code;
  assign out_field_length = head.field_length;
  assign out_field_null   = head.field_null;
  assign out_payload_byte = head.payload_byte;
  assign out_status       = head.status;
  assign out_last         = head.last;

endmodule

### rtl/core/rfsd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rfsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/rfsd_parser.sv
// Byte parser: phase sequencer, counters and the null bitmap store.
// Depends on rfsd_pkg and rfsd_ram.
module rfsd_parser #(
  parameter int MAX_BITMAP_BYTES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_accept,
  input  logic [7:0]     in_data_byte,
  input  logic           in_is_last,
  input  logic           in_no_data,
  output rfsd_pkg::push_t push
);

  localparam int AW = (MAX_BITMAP_BYTES > 1) ? $clog2(MAX_BITMAP_BYTES) : 1;
  localparam logic [16:0] MaxBytes = 17'(MAX_BITMAP_BYTES);

  rfsd_pkg::phase_t  phase_r, phase_nxt;
  logic [15:0]       field_total_r, field_total_nxt;
  logic [15:0]       bitmap_size_r, bitmap_size_nxt;
  logic [15:0]       byte_counter_r, byte_counter_nxt;
  logic [15:0]       current_field_r, current_field_nxt;
  logic [7:0]        current_type_r, current_type_nxt;
  logic [15:0]       current_length_r, current_length_nxt;
  logic [7:0]        low_byte_latch_r, low_byte_latch_nxt;
  rfsd_pkg::status_t error_code_r, error_code_nxt;

  logic          bm_wr_en;
  logic          bm_rd_en;
  logic [7:0]    bm_rd_data;
  logic          nul_bit;
  rfsd_pkg::res_t res0;
  rfsd_pkg::res_t res_end;
  logic          n0;
  logic          rec_end;

  // Null bitmap store; read on the type byte, used on the second length byte
  rfsd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BITMAP_BYTES)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (bm_wr_en),
    .wr_addr (byte_counter_r[AW-1:0]),
    .wr_data (in_data_byte),
    .rd_en   (bm_rd_en),
    .rd_addr (current_field_r[3 +: AW]),
    .rd_data (bm_rd_data)
  );

  assign nul_bit = bm_rd_data[current_field_r[2:0]];
  assign rec_end = in_accept && (in_no_data || in_is_last);

  // Next state and results
  always_comb begin
    logic [16:0] needed;
    logic [16:0] cnt_inc;
    logic [15:0] len_full;
    logic [15:0] fld_inc;

    phase_nxt          = phase_r;
    field_total_nxt    = field_total_r;
    bitmap_size_nxt    = bitmap_size_r;
    byte_counter_nxt   = byte_counter_r;
    current_field_nxt  = current_field_r;
    current_type_nxt   = current_type_r;
    current_length_nxt = current_length_r;
    low_byte_latch_nxt = low_byte_latch_r;
    error_code_nxt     = error_code_r;
    bm_wr_en = 1'b0;
    bm_rd_en = 1'b0;
    res0     = '0;
    res_end  = '0;
    n0       = 1'b0;
    needed   = ({1'b0, field_total_r} + 17'd7) >> 3;
    cnt_inc  = {1'b0, byte_counter_r} + 17'd1;
    len_full = {in_data_byte, low_byte_latch_r};
    fld_inc  = current_field_r + 16'd1;

    if (in_accept && !in_no_data) begin
      unique case (phase_r)
        rfsd_pkg::PH_HEAD: begin
          if (byte_counter_r == 16'd0 || byte_counter_r == 16'd2) begin
            low_byte_latch_nxt = in_data_byte;
            byte_counter_nxt   = cnt_inc[15:0];
          end else if (byte_counter_r == 16'd1) begin
            field_total_nxt  = len_full;
            byte_counter_nxt = cnt_inc[15:0];
          end else begin
            bitmap_size_nxt  = len_full;
            byte_counter_nxt = 16'd0;
            if ({1'b0, len_full} < needed) begin
              error_code_nxt = rfsd_pkg::ST_SHORT;
              phase_nxt      = rfsd_pkg::PH_ERROR;
            end else if (needed > MaxBytes) begin
              error_code_nxt = rfsd_pkg::ST_TOOMANY;
              phase_nxt      = rfsd_pkg::PH_ERROR;
            end else if (len_full != 16'd0) begin
              phase_nxt = rfsd_pkg::PH_BITMAP;
            end else begin
              phase_nxt = rfsd_pkg::PH_DONE;
            end
          end
        end
        rfsd_pkg::PH_BITMAP: begin
          // bytes beyond the store are consumed, not kept
          bm_wr_en = ({1'b0, byte_counter_r} < MaxBytes);
          if (cnt_inc >= {1'b0, bitmap_size_r}) begin
            byte_counter_nxt = 16'd0;
            phase_nxt = (field_total_r == 16'd0) ? rfsd_pkg::PH_DONE : rfsd_pkg::PH_TYPE;
          end else begin
            byte_counter_nxt = cnt_inc[15:0];
          end
        end
        rfsd_pkg::PH_TYPE: begin
          current_type_nxt = in_data_byte;
          byte_counter_nxt = 16'd0;
          phase_nxt        = rfsd_pkg::PH_LEN;
          bm_rd_en         = 1'b1;
        end
        rfsd_pkg::PH_LEN: begin
          if (byte_counter_r == 16'd0) begin
            low_byte_latch_nxt = in_data_byte;
            byte_counter_nxt   = 16'd1;
          end else begin
            current_length_nxt = len_full;
            byte_counter_nxt   = 16'd0;
            if (nul_bit && len_full != 16'd0) begin
              error_code_nxt = rfsd_pkg::ST_NULLPAY;
              phase_nxt      = rfsd_pkg::PH_ERROR;
            end else begin
              n0                = 1'b1;
              res0.kind         = rfsd_pkg::KIND_HEADER;
              res0.field_index  = current_field_r;
              res0.type_code    = current_type_r;
              res0.field_length = len_full;
              res0.field_null   = nul_bit;
              if (len_full == 16'd0) begin
                current_field_nxt = fld_inc;
                phase_nxt = (fld_inc == field_total_r) ? rfsd_pkg::PH_DONE
                                                       : rfsd_pkg::PH_TYPE;
              end else begin
                phase_nxt = rfsd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        rfsd_pkg::PH_PAYLOAD: begin
          n0                = 1'b1;
          res0.kind         = rfsd_pkg::KIND_PAYLOAD;
          res0.field_index  = current_field_r;
          res0.type_code    = current_type_r;
          res0.field_length = current_length_r;
          res0.payload_byte = in_data_byte;
          if (cnt_inc >= {1'b0, current_length_r}) begin
            byte_counter_nxt  = 16'd0;
            current_field_nxt = fld_inc;
            phase_nxt = (fld_inc == field_total_r) ? rfsd_pkg::PH_DONE
                                                   : rfsd_pkg::PH_TYPE;
          end else begin
            byte_counter_nxt = cnt_inc[15:0];
          end
        end
        rfsd_pkg::PH_DONE: begin
          error_code_nxt = rfsd_pkg::ST_TRAILING;
          phase_nxt      = rfsd_pkg::PH_ERROR;
        end
        rfsd_pkg::PH_ERROR: begin
          // swallow until the end of the record
        end
        default: begin
        end
      endcase
    end

    // End of record: status word, then back to the header phase
    if (rec_end) begin
      res_end.kind        = rfsd_pkg::KIND_END;
      res_end.field_index = current_field_nxt;
      res_end.last        = 1'b1;
      if (error_code_nxt != rfsd_pkg::ST_OK) begin
        res_end.status = error_code_nxt;
      end else if (phase_nxt == rfsd_pkg::PH_DONE) begin
        res_end.status = rfsd_pkg::ST_OK;
      end else begin
        res_end.status = rfsd_pkg::ST_TRUNC;
      end
      phase_nxt          = rfsd_pkg::PH_HEAD;
      field_total_nxt    = 16'd0;
      bitmap_size_nxt    = 16'd0;
      byte_counter_nxt   = 16'd0;
      current_field_nxt  = 16'd0;
      current_type_nxt   = 8'd0;
      current_length_nxt = 16'd0;
      low_byte_latch_nxt = 8'd0;
      error_code_nxt     = rfsd_pkg::ST_OK;
    end

    // Pack results in order
    push.cnt = {1'b0, n0} + {1'b0, rec_end};
    push.r0  = n0 ? res0 : res_end;
    push.r1  = res_end;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= rfsd_pkg::PH_HEAD;
      field_total_r    <= '0;
      bitmap_size_r    <= '0;
      byte_counter_r   <= '0;
      current_field_r  <= '0;
      current_type_r   <= '0;
      current_length_r <= '0;
      low_byte_latch_r <= '0;
      error_code_r     <= rfsd_pkg::ST_OK;
    end else begin
      phase_r          <= phase_nxt;
      field_total_r    <= field_total_nxt;
      bitmap_size_r    <= bitmap_size_nxt;
      byte_counter_r   <= byte_counter_nxt;
      current_field_r  <= current_field_nxt;
      current_type_r   <= current_type_nxt;
      current_length_r <= current_length_nxt;
      low_byte_latch_r <= low_byte_latch_nxt;
      error_code_r     <= error_code_nxt;
    end
  end

  // Checks
  a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rfsd_pkg::PH_ERROR |-> error_code_r != rfsd_pkg::ST_OK)
    else $error("error phase without an error code");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    rec_end |=> phase_r == rfsd_pkg::PH_HEAD && byte_counter_r == 16'd0 &&
                error_code_r == rfsd_pkg::ST_OK)
    else $error("record state not cleared after end of record");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.r1.kind == rfsd_pkg::KIND_END &&
                         push.r0.kind != rfsd_pkg::KIND_END)
    else $error("two results not in data then status order");

endmodule

### rtl/core/rfsd_out_fifo.sv
// Four-entry result queue taking up to two words per cycle and giving one per cycle unless the output stalls.
// Depends on rfsd_pkg.
module rfsd_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  rfsd_pkg::push_t push,
  input  logic            out_stall,
  output logic            out_valid,
  output rfsd_pkg::res_t  head,
  output logic            in_stall
);

  rfsd_pkg::res_t                mem_r [rfsd_pkg::OUT_DEPTH];
  logic [rfsd_pkg::OUT_AW-1:0]   head_r, head_nxt;
  logic [rfsd_pkg::OUT_AW-1:0]   tail_r, tail_nxt;
  logic [rfsd_pkg::OUT_CW-1:0]   count_r, count_nxt;
  logic                          pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[head_r];
  // room for two words must be left before a new input word is taken
  assign in_stall  = (count_r > rfsd_pkg::OUT_CW'(rfsd_pkg::OUT_DEPTH - 2));

  // Pointer and fill updates
  always_comb begin
    head_nxt  = head_r + rfsd_pkg::OUT_AW'(pop);
    tail_nxt  = tail_r + rfsd_pkg::OUT_AW'(push.cnt);
    count_nxt = count_r + rfsd_pkg::OUT_CW'(push.cnt) - rfsd_pkg::OUT_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[tail_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[tail_r + rfsd_pkg::OUT_AW'(1)] <= push.r1;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rfsd_pkg::OUT_CW'(rfsd_pkg::OUT_DEPTH))
    else $error("result queue overfilled");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> count_r <= rfsd_pkg::OUT_CW'(rfsd_pkg::OUT_DEPTH - 2))
    else $error("words pushed without room for two");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.cnt == 2'd0 |=> count_r == $past(count_r) - rfsd_pkg::OUT_CW'(1))
    else $error("fill count wrong after a lone pop");

endmodule
